// File: src/lne_pkg.sv
`default_nettype none
package lne_pkg;

	localparam int LNE_MAX_WIDTH  = 4096;
	localparam int LNE_PIXEL_BITS = 12;
	localparam int LNE_MAX_HEIGHT = 4096;
	localparam int LNE_ROW_W      = $clog2(LNE_MAX_HEIGHT);
	localparam int LNE_DIM_W      = 13;
	localparam int LNE_DEPTH_W    = 4;
	localparam int LNE_THR_W      = 12;
	localparam int LNE_CFG_W      = 13;
	localparam int LNE_SH_W       = 3;
	localparam int LNE_SUM_W      = 36;
	localparam int LNE_CNT_W      = 25;
	localparam int LNE_SIGMA_W    = 20;
	localparam int LNE_REM_W      = 48;
	localparam int LNE_MIN_SMOOTH = 16;
	localparam int LNE_OUT_W      = 88;

	typedef enum logic [1:0] {
		CFG_FRAME_WIDTH  = 2'd0,
		CFG_FRAME_HEIGHT = 2'd1,
		CFG_BIT_DEPTH    = 2'd2,
		CFG_GRAD_LIMIT   = 2'd3
	} lne_cfg_index_t;

	typedef struct packed {
		logic interior;
		logic last;
	} lne_ctl_t;

	typedef struct packed {
		logic [LNE_SUM_W-1:0]   sum;
		logic [LNE_CNT_W-1:0]   cnt;
	} lne_totals_t;

	typedef struct packed {
		logic [LNE_SUM_W-1:0]   sum;
		logic [LNE_CNT_W-1:0]   cnt;
		logic [LNE_SIGMA_W-1:0] sigma;
		logic                   est_valid;
	} lne_result_t;

endpackage
`default_nettype wire

// File: src/lne_ram.sv
`default_nettype none
module lne_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: src/lne_filter.sv
`default_nettype none
module lne_filter
	import lne_pkg::*;
#(
	parameter int PIXEL_BITS = LNE_PIXEL_BITS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             vld,
	input  wire lne_ctl_t                         ctl,
	input  wire logic [2:0][2:0][PIXEL_BITS-1:0]  win,
	input  wire logic [LNE_SH_W-1:0]              sh,
	input  wire logic [LNE_THR_W-1:0]             thr,
	output logic                                  fin_vld,
	output lne_totals_t                           fin
);

	localparam int GW = PIXEL_BITS + 5;

	function automatic logic [GW-1:0] rshift(input logic [GW-1:0] v,
			input logic [LNE_SH_W-1:0] s);
		logic [GW:0] t;
		t = {1'b0, v};
		if (s != '0) begin
			t = t + ((GW+1)'(1) << (s - LNE_SH_W'(1)));
		end
		return GW'(t >> s);
	endfunction

	function automatic logic signed [GW-1:0] sx(input logic [PIXEL_BITS-1:0] p);
		return $signed({{(GW-PIXEL_BITS){1'b0}}, p});
	endfunction

	function automatic logic [GW-1:0] absv(input logic signed [GW-1:0] v);
		return v[GW-1] ? GW'(-v) : GW'(v);
	endfunction

	logic signed [GW-1:0] a, b, c, d, e, f, g, h, i;
	logic signed [GW-1:0] gx, gy, lap;
	logic [GW-1:0]        mag;

	logic                 vld_s3;
	lne_ctl_t             ctl_s3;
	logic [GW-1:0]        mag_s3;
	logic [GW-1:0]        lap_s3;

	logic [LNE_SUM_W-1:0] sum_q;
	logic [LNE_CNT_W-1:0] cnt_q;
	logic [LNE_SUM_W:0]   sum_ext;
	logic [LNE_SUM_W-1:0] sum_nx;
	logic [LNE_CNT_W-1:0] cnt_nx;
	logic                 smooth;

	always_comb begin
		a = sx(win[0][0]); b = sx(win[1][0]); c = sx(win[2][0]);
		d = sx(win[0][1]); e = sx(win[1][1]); f = sx(win[2][1]);
		g = sx(win[0][2]); h = sx(win[1][2]); i = sx(win[2][2]);
		gx  = (a - c) + (g - i) + ((d - f) <<< 1);
		gy  = (a - g) + (c - i) + ((b - h) <<< 1);
		lap = (e <<< 2) - ((d + f + b + h) <<< 1) + (a + c + g + i);
		mag = absv(gx) + absv(gy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s3 <= ctl;
		mag_s3 <= rshift(mag, sh);
		lap_s3 <= rshift(absv(lap), sh);
	end

	always_comb begin
		smooth  = vld_s3 && ctl_s3.interior && (32'(mag_s3) < 32'(thr));
		sum_ext = {1'b0, sum_q} + (LNE_SUM_W+1)'(lap_s3);
		sum_nx  = sum_q;
		cnt_nx  = cnt_q;
		if (smooth) begin
			sum_nx = sum_ext[LNE_SUM_W] ? '1 : sum_ext[LNE_SUM_W-1:0];
			if (cnt_q != '1) begin
				cnt_nx = cnt_q + LNE_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			cnt_q   <= '0;
			fin_vld <= 1'b0;
		end else begin
			fin_vld <= vld_s3 && ctl_s3.last;
			if (vld_s3 && ctl_s3.last) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_nx;
				cnt_q <= cnt_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s3 && ctl_s3.last) begin
			fin.sum <= sum_nx;
			fin.cnt <= cnt_nx;
		end
	end

endmodule
`default_nettype wire

// File: src/lne_div.sv
`default_nettype none
module lne_div
	import lne_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire lne_totals_t tot,
	input  wire logic        take,
	output logic             done,
	output lne_result_t      res
);

	typedef enum logic [3:0] {
		DV_IDLE = 4'b0001,
		DV_MUL  = 4'b0010,
		DV_STEP = 4'b0100,
		DV_DONE = 4'b1000
	} dv_state_t;

	dv_state_t              state_q;
	logic [LNE_REM_W-1:0]   rem_q;
	logic [LNE_REM_W-1:0]   dsh_q;
	logic [4:0]             k_q;
	logic [LNE_SIGMA_W-1:0] quo_q;
	logic [LNE_SUM_W-1:0]   sum_q;
	logic [LNE_CNT_W-1:0]   cnt_q;
	logic                   est_q;
	logic                   ge;
	logic [LNE_REM_W-1:0]   sum_w;
	logic [LNE_REM_W-1:0]   cnt_w;

	always_comb begin
		ge    = rem_q >= dsh_q;
		sum_w = LNE_REM_W'(sum_q);
		cnt_w = LNE_REM_W'(cnt_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
		end else begin
			unique case (state_q)
				DV_IDLE: if (start) state_q <= DV_MUL;
				DV_MUL: begin
					if (32'(cnt_q) < LNE_MIN_SMOOTH) state_q <= DV_DONE;
					else state_q <= DV_STEP;
				end
				DV_STEP: begin
					if ((k_q == 5'd20 && ge) || k_q == 5'd0) state_q <= DV_DONE;
				end
				DV_DONE: if (take) state_q <= DV_IDLE;
				default: state_q <= DV_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			DV_IDLE: begin
				if (start) begin
					sum_q <= tot.sum;
					cnt_q <= tot.cnt;
				end
			end
			DV_MUL: begin
				rem_q <= (sum_w << 8) + (sum_w << 6) + sum_w + (cnt_w << 1) + cnt_w;
				dsh_q <= ((cnt_w << 2) + (cnt_w << 1)) << 20;
				k_q   <= 5'd20;
				quo_q <= '0;
				est_q <= 32'(cnt_q) >= LNE_MIN_SMOOTH;
			end
			DV_STEP: begin
				if (k_q == 5'd20) begin
					if (ge) quo_q <= '1;
				end else if (ge) begin
					rem_q <= rem_q - dsh_q;
					quo_q <= quo_q | (LNE_SIGMA_W'(1) << k_q);
				end
				dsh_q <= dsh_q >> 1;
				k_q   <= k_q - 5'd1;
			end
			DV_DONE: ;
			default: ;
		endcase
	end

	always_comb begin
		done          = state_q == DV_DONE;
		res.sum       = sum_q;
		res.cnt       = cnt_q;
		res.sigma     = quo_q;
		res.est_valid = est_q;
	end

endmodule
`default_nettype wire

// File: src/laplacian_noise_estimator.sv
`default_nettype none
// Noise estimator for one frame of pixels in raster order. Interior pixels with a Sobel
// magnitude below the gradient limit add their |Laplacian| to a sum; after the last pixel one
// request carries sigma (Q8), the sum and the count, with tuser high when at least sixteen
// pixels were smooth. Inside a frame a pixel is taken every clock: the two line memories
// are read in the cycle a pixel is accepted and written back in the next one. After the
// last pixel of a frame, input is held: the pipeline stages s1 to s3 and the filter's totals
// register drain, then the serial divider loads the totals, forms the product and works out
// the quotient bits, and the result moves into the output register. Input stays held
// longer while an earlier result still waits in the output register to be taken.
module laplacian_noise_estimator
	import lne_pkg::*;
#(
	parameter int MAX_WIDTH  = LNE_MAX_WIDTH,
	parameter int PIXEL_BITS = LNE_PIXEL_BITS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  wire logic [((PIXEL_BITS+7)/8)*8-1:0]   s_axis_tdata,  // pixel
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	output logic [LNE_OUT_W-1:0]                   m_axis_tdata,  // sigma_q8, smooth_count, laplacian_sum
	output logic                                   m_axis_tuser,  // estimate_valid
	input  wire logic                              cfg_we,
	input  wire logic [1:0]                        cfg_index,
	input  wire logic [LNE_CFG_W-1:0]              cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic [LNE_DIM_W-1:0]   frame_width_q;
	logic [LNE_DIM_W-1:0]   frame_height_q;
	logic [LNE_DEPTH_W-1:0] bit_depth_q;
	logic [LNE_THR_W-1:0]   grad_limit_q;

	logic [CW:0]            w_lim;
	logic [LNE_DIM_W-1:0]   h_lim;
	logic [LNE_SH_W-1:0]    sh;
	logic [CW-1:0]          col_q;
	logic [LNE_ROW_W-1:0]   row_q;
	logic                   ready_q;
	logic                   accept;
	logic                   end_row;
	logic                   end_frame;

	logic                   vld_s1;
	lne_ctl_t               ctl_s1;
	logic [CW-1:0]          col_s1;
	logic [PIXEL_BITS-1:0]  pix_s1;
	logic                   vld_s2;
	lne_ctl_t               ctl_s2;
	logic [PIXEL_BITS-1:0]  up_rd;
	logic [PIXEL_BITS-1:0]  mid_rd;
	logic [2:0][2:0][PIXEL_BITS-1:0] win_q;

	logic                   fin_vld;
	lne_totals_t            fin;
	logic                   div_done;
	lne_result_t            div_res;
	logic                   take;
	lne_result_t            out_q;
	logic                   out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= LNE_DIM_W'(1920);
			frame_height_q <= LNE_DIM_W'(1080);
			bit_depth_q    <= LNE_DEPTH_W'(8);
			grad_limit_q   <= LNE_THR_W'(50);
		end else if (cfg_we) begin
			unique case (lne_cfg_index_t'(cfg_index))
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				CFG_BIT_DEPTH:    bit_depth_q    <= cfg_data[LNE_DEPTH_W-1:0];
				CFG_GRAD_LIMIT:   grad_limit_q   <= cfg_data[LNE_THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (32'(frame_width_q) < 32'd3) w_lim = (CW+1)'(3);
		else if (32'(frame_width_q) > 32'(MAX_WIDTH)) w_lim = (CW+1)'(MAX_WIDTH);
		else w_lim = (CW+1)'(frame_width_q);
		if (32'(frame_height_q) < 32'd3) h_lim = LNE_DIM_W'(3);
		else if (32'(frame_height_q) > 32'(LNE_MAX_HEIGHT)) h_lim = LNE_DIM_W'(LNE_MAX_HEIGHT);
		else h_lim = frame_height_q;
		if (bit_depth_q < LNE_DEPTH_W'(8)) sh = '0;
		else if (bit_depth_q > LNE_DEPTH_W'(12)) sh = LNE_SH_W'(4);
		else sh = LNE_SH_W'(bit_depth_q - LNE_DEPTH_W'(8));
		accept    = s_axis_tvalid && ready_q;
		end_row   = ({1'b0, col_q} + (CW+1)'(1)) >= w_lim;
		end_frame = (LNE_DIM_W'(row_q) + LNE_DIM_W'(1)) >= h_lim;
		take      = div_done && (!out_vld_q || m_axis_tready);
		s_axis_tready = ready_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			ready_q <= 1'b1;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			if (accept) begin
				if (end_row) begin
					col_q <= '0;
					if (end_frame) begin
						row_q   <= '0;
						ready_q <= 1'b0;
					end else begin
						row_q <= row_q + LNE_ROW_W'(1);
					end
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (take) ready_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1          <= col_q;
			pix_s1          <= s_axis_tdata[PIXEL_BITS-1:0];
			ctl_s1.interior <= (32'(col_q) >= 32'd2) && (32'(row_q) >= 32'd2);
			ctl_s1.last     <= end_row && end_frame;
		end
		ctl_s2 <= ctl_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (vld_s1) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= {pix_s1, mid_rd, up_rd};
		end
	end

	lne_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_upper (
		.clk   (clk),
		.we    (vld_s1),
		.waddr (col_s1),
		.wdata (mid_rd),
		.raddr (col_q),
		.rdata (up_rd)
	);

	lne_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_middle (
		.clk   (clk),
		.we    (vld_s1),
		.waddr (col_s1),
		.wdata (pix_s1),
		.raddr (col_q),
		.rdata (mid_rd)
	);

	lne_filter #(.PIXEL_BITS(PIXEL_BITS)) u_filter (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (vld_s2),
		.ctl     (ctl_s2),
		.win     (win_q),
		.sh      (sh),
		.thr     (grad_limit_q),
		.fin_vld (fin_vld),
		.fin     (fin)
	);

	lne_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (fin_vld),
		.tot    (fin),
		.take   (take),
		.done   (div_done),
		.res    (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (take) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) out_q <= div_res;
	end

	always_comb begin
		m_axis_tvalid = out_vld_q;
		m_axis_tuser  = out_q.est_valid;
		m_axis_tdata  = {7'b0, out_q.sum, out_q.cnt, out_q.sigma};
	end

endmodule
`default_nettype wire
